// ===== hw/rtl/klisr_pkg.sv =====
// klisr_pkg: shared widths, operation codes and result status codes for the
// keyed entry table. No dependencies; imported by the table and its checker.
package klisr_pkg;

    localparam int DEPTH      = 16;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int KEY_W      = 64;
    localparam int HANDLE_W   = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int ENTRY_W    = KEY_W + HANDLE_W;
    localparam int IN_DATA_W  = ((KEY_W + HANDLE_W + 7) / 8) * 8;
    localparam int OUT_RAW_W  = IDX_W + HANDLE_W + CNT_W + 2;
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;

endpackage

// ===== hw/rtl/keyed_list_insert_search_remove.sv =====
// keyed_list_insert_search_remove: keyed entry table with add, search and remove,
// one shared key comparator and a 1R1W entry memory under a small sequencer.
// Depends on klisr_pkg.
//
// Channels: a transfer on the slave side (s_tvalid/s_tready) carries one request:
// s_tuser is the operation (0 add, 1 search, 2 remove, 3 acts as search) and
// s_tdata the key and record handle. Each request gives exactly one result on the
// master side: m_tuser is the status, m_tdata the index, handle, count and flags.
// cfg_valid/cfg_ready write the capacity register (saturated to the table depth).
// Sequencing: the sequencer visits entries one at a time, in a read state and then
// a compare state. A remove hit then moves each later entry down one place, with
// a read state and a write state per entry, before it finishes.
// s_tready is high only while the sequencer is idle, one request at a time.
// A finished result sits in the output register; a new request may be taken while
// it waits, and that request's result is held until m_tready takes the old one.
// Reset empties the table (count zero) and sets capacity to 16; entry contents
// are not cleared, as only positions below the count are ever read.
module keyed_list_insert_search_remove
    import klisr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // key [63:0], record_handle [95:64]
    input  logic [FUNC_W-1:0]     s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // entry_index, found_handle, count,
                                             // empty_flag, full_flag, zero pad
    output logic [STATUS_W-1:0]   m_tuser,   // status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data   // capacity
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_READ     = 3'd1;
    localparam logic [2:0] S_CMP      = 3'd2;
    localparam logic [2:0] S_MISS     = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    cap_reg;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_idx_reg, res_idx_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_empty_reg;
    logic                out_full_reg;

    logic [ENTRY_W-1:0]  mem [DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                mem_we;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    logic                in_xfer;
    logic                out_free;
    logic                load_out;
    logic [CNT_W-1:0]    eff_cap;
    logic [CNT_W-1:0]    idx_plus1;
    logic                key_match;
    logic                at_full;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign load_out  = (state_reg == S_FINISH) && out_free;

    assign eff_cap   = (cap_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_reg;
    assign idx_plus1 = {1'b0, idx_reg} + CNT_W'(1);
    assign key_match = (rd_data_reg[KEY_W-1:0] == key_reg);
    assign at_full   = (count_reg >= eff_cap);

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        handle_next     = handle_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_handle_next = res_handle_reg;
        rd_addr         = idx_reg;
        mem_we          = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next   = s_tuser;
                    key_next    = s_tdata[KEY_W-1:0];
                    handle_next = s_tdata[KEY_W +: HANDLE_W];
                    idx_next    = '0;
                    state_next  = (count_reg == '0) ? S_MISS : S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (key_match)
                begin
                    res_idx_next    = idx_reg;
                    res_handle_next = '0;
                    if (func_reg == FUNC_ADD)
                    begin
                        res_status_next = ST_DUP;
                        res_idx_next    = '0;
                        state_next      = S_FINISH;
                    end
                    else if (func_reg == FUNC_REMOVE)
                    begin
                        res_status_next = ST_REMOVED;
                        state_next      = S_SHIFT_RD;
                    end
                    else
                    begin
                        res_status_next = ST_FOUND;
                        res_handle_next = rd_data_reg[KEY_W +: HANDLE_W];
                        state_next      = S_FINISH;
                    end
                end
                else if (idx_plus1 >= count_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    idx_next   = idx_plus1[IDX_W-1:0];
                    state_next = S_READ;
                end
            end
            S_MISS:
            begin
                res_handle_next = '0;
                res_idx_next    = '0;
                if (func_reg == FUNC_ADD)
                begin
                    if (at_full)
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we          = 1'b1;
                        wr_addr         = count_reg[IDX_W-1:0];
                        wr_data         = {handle_reg, key_reg};
                        res_status_next = ST_ADDED;
                        res_idx_next    = count_reg[IDX_W-1:0];
                        count_next      = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    res_status_next = ST_NOTFOUND;
                end
                state_next = S_FINISH;
            end
            S_SHIFT_RD:
            begin
                // pull the next entry down one place to close the gap
                if (idx_plus1 < count_reg)
                begin
                    rd_addr    = idx_plus1[IDX_W-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_FINISH;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data_reg;
                idx_next   = idx_plus1[IDX_W-1:0];
                state_next = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        handle_reg     <= handle_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_handle_reg <= res_handle_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_idx_reg    <= res_idx_reg;
            out_handle_reg <= res_handle_reg;
            out_count_reg  <= count_reg;
            out_empty_reg  <= (count_reg == '0);
            out_full_reg   <= at_full;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(OUT_DATA_W - OUT_RAW_W)'(0), out_full_reg, out_empty_reg,
                       out_count_reg, out_handle_reg, out_idx_reg};

endmodule

// ===== hw/rtl/klisr_checker.sv =====
// klisr_checker: port-level assertions for keyed_list_insert_search_remove,
// bound to the top level below. Depends on klisr_pkg.
module klisr_checker
    import klisr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]   m_tuser
);

    // the sequencer is busy in the cycle after it takes a request
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high straight after a request transfer");

    // a stalled result is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_REMOVED)
        else $error("status code out of range");

    // empty flag agrees with the reported count, which never exceeds the depth
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[IDX_W+HANDLE_W+CNT_W] ==
                      (m_tdata[IDX_W+HANDLE_W +: CNT_W] == '0))
                     && (m_tdata[IDX_W+HANDLE_W +: CNT_W] <= CNT_W'(DEPTH)))
        else $error("empty flag or count inconsistent");

endmodule

bind keyed_list_insert_search_remove klisr_checker u_klisr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
